// ----- hdl/bfrt_pkg.sv -----
// Shared types and constants for the brace fold region tracker.
// Depends on nothing; bfrt_scanner, bfrt_result and the top refer to it by scoped names.
`default_nettype none
package bfrt_pkg;

    // Character codes the scanner reacts to
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // Result field widths on the output beat
    localparam int OUT_LINE_W = 20;
    localparam int OUT_COL_W  = 16;
    localparam int OUT_DATA_W = 2 * OUT_LINE_W + 2 * OUT_COL_W;

    // Result kinds
    localparam logic KIND_FOLD     = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    // Stack operation issued by the scanner for one accepted byte
    typedef struct packed {
        logic push;
        logic pop;
        logic ovf;
    } bfrt_op_t;

endpackage
`default_nettype wire

// ----- hdl/bfrt_scanner.sv -----
// Byte scanner: line/column counters, string/comment flags, stack depth.
// Issues push/pop/overflow operations for the stack memory. Uses bfrt_pkg.
`default_nettype none
module bfrt_scanner #(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_BITS   = 20,
    parameter int COL_BITS    = 16,
    parameter int AW          = 6,
    parameter int DW          = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [7:0]           ch,
    input  wire logic                 doc_start,
    output bfrt_pkg::bfrt_op_t        op,
    output logic [AW-1:0]             addr,
    output logic [LINE_BITS-1:0]      pos_line,
    output logic [COL_BITS-1:0]       pos_col
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COL_BITS-1:0]  COL_MAX  = {COL_BITS{1'b1}};
    localparam logic [DW-1:0]        DEPTH_FULL = DW'(STACK_DEPTH);

    logic [LINE_BITS-1:0] line_reg, line_next, line_b;
    logic [COL_BITS-1:0]  col_reg, col_next, col_b;
    logic                 str_reg, str_next, str_b;
    logic [7:0]           quote_reg, quote_next, quote_b;
    logic                 com_reg, com_next, com_b;
    logic                 esc_reg, esc_next, esc_b;
    logic                 slash_reg, slash_next, slash_b;
    logic [DW-1:0]        depth_reg, depth_next, depth_b;

    logic [COL_BITS:0]    col_p1, col_p2;
    logic [COL_BITS-1:0]  col_sat1, col_sat2;
    logic [DW-1:0]        depth_m1;
    logic                 handled;

    // State as seen by this byte: a document start clears it first
    always_comb
    begin
        if (doc_start)
        begin
            line_b  = '0;
            col_b   = '0;
            str_b   = 1'b0;
            quote_b = bfrt_pkg::CH_DQUOTE;
            com_b   = 1'b0;
            esc_b   = 1'b0;
            slash_b = 1'b0;
            depth_b = '0;
        end
        else
        begin
            line_b  = line_reg;
            col_b   = col_reg;
            str_b   = str_reg;
            quote_b = quote_reg;
            com_b   = com_reg;
            esc_b   = esc_reg;
            slash_b = slash_reg;
            depth_b = depth_reg;
        end
    end

    // Saturating column increments
    always_comb
    begin
        col_p1   = {1'b0, col_b} + {{COL_BITS{1'b0}}, 1'b1};
        col_p2   = {1'b0, col_b} + (COL_BITS+1)'(2);
        col_sat1 = col_p1[COL_BITS] ? COL_MAX : col_p1[COL_BITS-1:0];
        col_sat2 = col_p2[COL_BITS] ? COL_MAX : col_p2[COL_BITS-1:0];
        depth_m1 = depth_b - {{(DW-1){1'b0}}, 1'b1};
    end

    // Byte rules in priority order
    always_comb
    begin
        line_next  = line_b;
        col_next   = col_b;
        str_next   = str_b;
        quote_next = quote_b;
        com_next   = com_b;
        esc_next   = esc_b;
        slash_next = slash_b;
        depth_next = depth_b;
        op         = '0;
        addr       = depth_b[AW-1:0];
        handled    = 1'b0;

        if (esc_b)
        begin
            esc_next = 1'b0;
            handled  = 1'b1;
        end
        else if (slash_b)
        begin
            slash_next = 1'b0;
            if (ch == bfrt_pkg::CH_SLASH)
            begin
                com_next = 1'b1;
                col_next = col_sat1;
                handled  = 1'b1;
            end
        end

        if (!handled)
        begin
            if (ch == bfrt_pkg::CH_NEWLINE)
            begin
                if (line_b != LINE_MAX)
                    line_next = line_b + {{(LINE_BITS-1){1'b0}}, 1'b1};
                col_next = '0;
                com_next = 1'b0;
            end
            else if (com_b)
            begin
                col_next = col_sat1;
            end
            else if (str_b)
            begin
                if (ch == bfrt_pkg::CH_BACKSLASH)
                begin
                    esc_next = 1'b1;
                    col_next = col_sat2;
                end
                else
                begin
                    if (ch == quote_b)
                        str_next = 1'b0;
                    col_next = col_sat1;
                end
            end
            else if (ch == bfrt_pkg::CH_SLASH)
            begin
                slash_next = 1'b1;
                col_next   = col_sat1;
            end
            else if (ch == bfrt_pkg::CH_DQUOTE || ch == bfrt_pkg::CH_SQUOTE)
            begin
                str_next   = 1'b1;
                quote_next = ch;
                col_next   = col_sat1;
            end
            else if (ch == bfrt_pkg::CH_LBRACE)
            begin
                if (depth_b < DEPTH_FULL)
                begin
                    op.push    = 1'b1;
                    depth_next = depth_b + {{(DW-1){1'b0}}, 1'b1};
                end
                else
                    op.ovf = 1'b1;
                col_next = col_sat1;
            end
            else if (ch == bfrt_pkg::CH_RBRACE)
            begin
                if (depth_b != '0)
                begin
                    op.pop     = 1'b1;
                    addr       = depth_m1[AW-1:0];
                    depth_next = depth_m1;
                end
                col_next = col_sat1;
            end
            else
                col_next = col_sat1;
        end

        op.push = op.push & accept;
        op.pop  = op.pop & accept;
        op.ovf  = op.ovf & accept;
    end

    // Position of the current byte, before its own column step
    assign pos_line = line_b;
    assign pos_col  = col_b;

    // Scanner state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg  <= '0;
            col_reg   <= '0;
            str_reg   <= 1'b0;
            quote_reg <= bfrt_pkg::CH_DQUOTE;
            com_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            slash_reg <= 1'b0;
            depth_reg <= '0;
        end
        else if (accept)
        begin
            line_reg  <= line_next;
            col_reg   <= col_next;
            str_reg   <= str_next;
            quote_reg <= quote_next;
            com_reg   <= com_next;
            esc_reg   <= esc_next;
            slash_reg <= slash_next;
            depth_reg <= depth_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/bfrt_stack_mem.sv -----
// Open-brace position stack: one synchronous RAM, one write and one read port.
// Read data is registered and holds until the next read. Uses no package items.
`default_nettype none
module bfrt_stack_mem #(
    parameter int STACK_DEPTH = 64,
    parameter int WIDTH       = 36,
    parameter int AW          = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [STACK_DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hdl/bfrt_result.sv -----
// Result stage: compares the popped entry with the closing brace position and
// feeds a registered output beat. Uses bfrt_pkg for widths and kinds.
`default_nettype none
module bfrt_result #(
    parameter int LINE_BITS = 20,
    parameter int COL_BITS  = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire logic                           load_ovf,
    input  wire logic [LINE_BITS-1:0]           line_in,
    input  wire logic [COL_BITS-1:0]            col_in,
    input  wire logic [LINE_BITS+COL_BITS-1:0]  rd_entry,
    output logic                                ready,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                out_kind,
    output logic [bfrt_pkg::OUT_DATA_W-1:0]     out_data
);

    localparam int LW = bfrt_pkg::OUT_LINE_W;
    localparam int CW = bfrt_pkg::OUT_COL_W;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_ovf_reg;
    logic [LINE_BITS-1:0] s1_line_reg;
    logic [COL_BITS-1:0]  s1_col_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg;
    logic [bfrt_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [LINE_BITS-1:0] rd_line;
    logic [COL_BITS-1:0]  rd_col;
    logic                 can_move, hit;
    logic [bfrt_pkg::OUT_DATA_W-1:0] res_data;

    assign rd_line = rd_entry[LINE_BITS+COL_BITS-1:COL_BITS];
    assign rd_col  = rd_entry[COL_BITS-1:0];

    // Stage 1 drains whenever the output register is free or being taken
    assign can_move = !out_valid_reg || out_ready;
    assign ready    = !s1_valid_reg || can_move;
    assign hit      = s1_valid_reg && (s1_ovf_reg || (s1_line_reg > rd_line));

    always_comb
    begin
        if (s1_ovf_reg)
            res_data = {{CW{1'b0}}, {LW{1'b0}}, CW'(s1_col_reg), LW'(s1_line_reg)};
        else
            res_data = {CW'(s1_col_reg), LW'(s1_line_reg), CW'(rd_col), LW'(rd_line)};
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (can_move)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = hit;
        end
        if (load)
            s1_valid_next = 1'b1;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_ovf_reg  <= load_ovf;
            s1_line_reg <= line_in;
            s1_col_reg  <= col_in;
        end
        if (can_move && hit)
        begin
            out_kind_reg <= s1_ovf_reg ? bfrt_pkg::KIND_OVERFLOW : bfrt_pkg::KIND_FOLD;
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ----- hdl/brace_fold_region_tracker_top.sv -----
// Brace fold region tracker, top level.
// Depends on bfrt_pkg, bfrt_scanner, bfrt_stack_mem and bfrt_result.
//
// Usage:
//   s_axis carries one source byte per beat (tdata = ch, tuser = doc_start;
//   doc_start clears all tracking state before its byte is scanned).
//   m_axis carries fold regions (tuser kind 0) and stack overflows (kind 1)
//   with open and close line and column packed into tdata.
// Throughput: one byte per cycle when not stalled. The scanner state sits in
//   flip-flops and the brace stack in a single-port-write, registered-read RAM;
//   a push writes at the accept edge, so a later pop always reads fresh data.
// Pipeline: a result for a '}' or '{' beat passes the RAM read plus compare
//   stage, then the output register.
// Stall: with m_axis_tready low, bytes are still taken until a result-capable
//   beat ('{' on a full stack or '}' with a non-empty stack) sits in the compare
//   stage behind a held result; s_axis_tready then drops until the output drains.
// Reset: rst_n clears counters, flags, stack depth and all valid flags; the
//   stack RAM is not cleared, only entries below the depth are ever read.
`default_nettype none
module brace_fold_region_tracker_top #(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_BITS   = 20,
    parameter int COL_BITS    = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tuser,   // [0] doc_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [bfrt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [19:0] open line, [35:20] open col, [55:36] close line, [71:56] close col
    output logic             m_axis_tuser    // [0] kind
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int EW = LINE_BITS + COL_BITS;

    logic                 accept;
    bfrt_pkg::bfrt_op_t   op;
    logic [AW-1:0]        addr;
    logic [LINE_BITS-1:0] pos_line;
    logic [COL_BITS-1:0]  pos_col;
    logic [EW-1:0]        rd_entry;

    assign accept = s_axis_tvalid && s_axis_tready;

    bfrt_scanner #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS),
        .COL_BITS    (COL_BITS),
        .AW          (AW),
        .DW          (DW)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ch        (s_axis_tdata),
        .doc_start (s_axis_tuser),
        .op        (op),
        .addr      (addr),
        .pos_line  (pos_line),
        .pos_col   (pos_col)
    );

    bfrt_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .WIDTH       (EW),
        .AW          (AW)
    ) u_stack (
        .clk   (clk),
        .we    (op.push),
        .waddr (addr),
        .wdata ({pos_line, pos_col}),
        .re    (op.pop),
        .raddr (addr),
        .rdata (rd_entry)
    );

    bfrt_result #(
        .LINE_BITS (LINE_BITS),
        .COL_BITS  (COL_BITS)
    ) u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (op.pop || op.ovf),
        .load_ovf  (op.ovf),
        .line_in   (pos_line),
        .col_in    (pos_col),
        .rd_entry  (rd_entry),
        .ready     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ----- test/bfrt_checker.sv -----
// Scoreboard for the brace fold region tracker: watches both stream channels,
// predicts fold and overflow results from the accepted source bytes and compares.
// Depends on bfrt_pkg for character codes, result kinds and output widths.
module bfrt_checker #(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_BITS   = 20,
    parameter int COL_BITS    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] ch
    input  logic                            s_axis_tuser,   // [0] doc_start
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [bfrt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [19:0] open line, [35:20] open col, [55:36] close line, [71:56] close col
    input  logic                            m_axis_tuser,   // [0] kind
    output int                              fail_count,
    output int                              regions_waiting,
    output int                              bytes_seen,
    output int                              folds_seen,
    output int                              overflows_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import bfrt_pkg::*;

    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
    localparam logic [COL_BITS-1:0]  COL_TOP  = '1;
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef struct packed {
        logic                  kind;
        logic [OUT_LINE_W-1:0] open_ln;
        logic [OUT_COL_W-1:0]  open_cl;
        logic [OUT_LINE_W-1:0] close_ln;
        logic [OUT_COL_W-1:0]  close_cl;
    } region_t;

    // Scanner state mirrored from the accepted byte stream
    logic [LINE_BITS-1:0] scan_line;
    logic [COL_BITS-1:0]  scan_col;
    logic                 in_str;
    logic [7:0]           quote_ch;
    logic                 in_cmt;
    logic                 esc_pend;
    logic                 slash_pend;
    int                   brace_depth;
    logic [LINE_BITS-1:0] open_line [STACK_DEPTH];
    logic [COL_BITS-1:0]  open_col  [STACK_DEPTH];

    region_t expected_regions[$];
    int      fails;
    int      n_bytes;
    int      n_folds;
    int      n_ovfs;

    task automatic clear_scanner();
        scan_line   = '0;
        scan_col    = '0;
        in_str      = 1'b0;
        quote_ch    = CH_DQUOTE;
        in_cmt      = 1'b0;
        esc_pend    = 1'b0;
        slash_pend  = 1'b0;
        brace_depth = 0;
    endtask

    // Column advance with saturation at the counter's top value
    task automatic col_advance(input int unsigned n);
        logic [COL_BITS+1:0] sum;
        sum = {2'b00, scan_col} + (COL_BITS+2)'(n);
        if (sum > {2'b00, COL_TOP})
            scan_col = COL_TOP;
        else
            scan_col = sum[COL_BITS-1:0];
    endtask

    // Queue one predicted result at the tail
    task automatic add_expected(input region_t r);
        expected_regions.insert(expected_regions.size(), r);
    endtask

    // One source byte through the tracker rules, highest priority first
    task automatic scan_byte(input logic [7:0] ch, input logic doc);
        logic    handled;
        region_t r;
        handled = 1'b0;
        if (doc)
            clear_scanner();
        if (esc_pend)
        begin
            // byte after a backslash in a string is swallowed whole
            esc_pend = 1'b0;
        end
        else
        begin
            if (slash_pend)
            begin
                slash_pend = 1'b0;
                if (ch == CH_SLASH)
                begin
                    in_cmt = 1'b1;
                    col_advance(1);
                    handled = 1'b1;
                end
            end
            if (!handled)
            begin
                if (ch == CH_NEWLINE)
                begin
                    if (scan_line != LINE_TOP)
                        scan_line = scan_line + 1'b1;
                    scan_col = '0;
                    in_cmt   = 1'b0;
                end
                else if (in_cmt)
                begin
                    col_advance(1);
                end
                else if (in_str)
                begin
                    if (ch == CH_BACKSLASH)
                    begin
                        esc_pend = 1'b1;
                        col_advance(2);
                    end
                    else
                    begin
                        if (ch == quote_ch)
                            in_str = 1'b0;
                        col_advance(1);
                    end
                end
                else if (ch == CH_SLASH)
                begin
                    slash_pend = 1'b1;
                    col_advance(1);
                end
                else if (ch == CH_DQUOTE || ch == CH_SQUOTE)
                begin
                    in_str   = 1'b1;
                    quote_ch = ch;
                    col_advance(1);
                end
                else
                begin
                    if (ch == CH_LBRACE)
                    begin
                        if (brace_depth < STACK_DEPTH)
                        begin
                            open_line[brace_depth[SAW-1:0]] = scan_line;
                            open_col[brace_depth[SAW-1:0]]  = scan_col;
                            brace_depth++;
                        end
                        else
                        begin
                            // full stack: brace dropped, reported
                            r.kind     = KIND_OVERFLOW;
                            r.open_ln  = scan_line;
                            r.open_cl  = scan_col;
                            r.close_ln = '0;
                            r.close_cl = '0;
                            add_expected(r);
                        end
                    end
                    else if (ch == CH_RBRACE && brace_depth > 0)
                    begin
                        brace_depth--;
                        // single-line pairs pop silently
                        if (scan_line > open_line[brace_depth[SAW-1:0]])
                        begin
                            r.kind     = KIND_FOLD;
                            r.open_ln  = open_line[brace_depth[SAW-1:0]];
                            r.open_cl  = open_col[brace_depth[SAW-1:0]];
                            r.close_ln = scan_line;
                            r.close_cl = scan_col;
                            add_expected(r);
                        end
                    end
                    col_advance(1);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Compare one output beat with the oldest prediction
    task automatic check_result();
        region_t r;
        if (expected_regions.size() == 0)
        begin
            $error("unexpected result beat: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
            fails++;
        end
        else
        begin
            r = expected_regions.pop_front();
            check_field("kind", r.kind, m_axis_tuser);
            check_field("open_ln", r.open_ln, m_axis_tdata[19:0]);
            check_field("open_cl", r.open_cl, m_axis_tdata[35:20]);
            check_field("close_ln", r.close_ln, m_axis_tdata[55:36]);
            check_field("close_cl", r.close_cl, m_axis_tdata[71:56]);
        end
        if (m_axis_tuser == KIND_FOLD)
            n_folds++;
        else
            n_ovfs++;
    endtask

    // Sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scanner();
            expected_regions.delete();
            fails   = 0;
            n_bytes = 0;
            n_folds = 0;
            n_ovfs  = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
            begin
                n_bytes++;
                scan_byte(s_axis_tdata, s_axis_tuser);
            end
        end
        fail_count      <= fails;
        regions_waiting <= expected_regions.size();
        bytes_seen      <= n_bytes;
        folds_seen      <= n_folds;
        overflows_seen  <= n_ovfs;
    end

endmodule

// ----- test/brace_fold_region_tracker_top_tb.sv -----
// Testbench top for the brace fold region tracker: clock, reset, byte stimulus,
// result-side backpressure and the verdict. Depends on bfrt_pkg, bfrt_checker and the RTL.
module brace_fold_region_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfrt_pkg::*;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_CYCLES  = 400;

    logic clk           = 1'b0;
    logic rst_n         = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [7:0] ch
    logic s_axis_tuser  = 1'b0;      // [0] doc_start
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [19:0] open line, [35:20] open col, [55:36] close line, [71:56] close col
    logic m_axis_tuser;              // [0] kind

    int fail_count;
    int regions_waiting;
    int bytes_seen;
    int folds_seen;
    int overflows_seen;

    // Idle and hold controls for the source task and the sink process
    logic src_idle_en  = 1'b0;
    logic sink_idle_en = 1'b0;
    int   hold_req     = 0;
    int   hold_seen;
    int   hold_left;
    int   sink_gap;
    int   n_sent       = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    brace_fold_region_tracker_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bfrt_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .regions_waiting (regions_waiting),
        .bytes_seen      (bytes_seen),
        .folds_seen      (folds_seen),
        .overflows_seen  (overflows_seen)
    );

    // Result sink: long hold on request, otherwise random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
            sink_gap  = 0;
        end
        else
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                sink_gap = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // One source beat, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] ch, input logic doc);
        int gap;
        if (src_idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= doc;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_sent++;
    endtask

    // Byte mix weighted toward the characters the scanner reacts to
    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 15))
            0, 1, 2: return CH_LBRACE;
            3, 4, 5: return CH_RBRACE;
            6, 7:    return CH_NEWLINE;
            8:       return CH_DQUOTE;
            9:       return CH_SQUOTE;
            10:      return CH_BACKSLASH;
            11:      return CH_SLASH;
            12:      return CH_SPACE;
            default: return CH_LOWER_A + 8'($urandom_range(0, 25));
        endcase
    endfunction

    initial
    begin
        int base;
        int len;
        int nest;
        int seg;
        int waited;
        logic doc;
        logic first_seg;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: folds, same-line pair, unmatched close, strings, comments
        src_idle_en = 1'b1;
        sink_idle_en <= 1'b1;
        send_byte(CH_LBRACE, 1'b1);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
        send_byte(CH_LBRACE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_LBRACE, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_SQUOTE, 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_SQUOTE, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte(CH_LBRACE, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte(CH_LBRACE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
        // escape and slash left pending across a document start
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_SLASH, 1'b1);
        send_byte(CH_SLASH, 1'b1);
        send_byte(CH_LBRACE, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);

        // Backpressure: sink holds off while a fold every three bytes keeps coming
        src_idle_en = 1'b0;
        hold_req <= hold_req + 1;
        repeat (30)
        begin
            send_byte(CH_LBRACE, 1'b0);
            send_byte(CH_NEWLINE, 1'b0);
            send_byte(CH_RBRACE, 1'b0);
        end

        // Random segments: mostly brace text, some deep nests, some raw noise
        base = n_sent;
        first_seg = 1'b1;
        while (n_sent - base < RANDOM_ITEMS)
        begin
            src_idle_en = ($urandom_range(0, 3) != 0);
            sink_idle_en <= ($urandom_range(0, 3) != 0);
            seg = first_seg ? 1 : $urandom_range(0, 9);
            case (seg)
                0:
                begin
                    len = $urandom_range(4, 20);
                    repeat (len)
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
                end
                1:
                begin
                    // nest past the stack limit on the first one
                    nest = first_seg ? 68 : $urandom_range(40, 72);
                    for (int i = 0; i < nest; i++)
                    begin
                        send_byte(CH_LBRACE, first_seg && i == 0);
                        if ($urandom_range(0, 3) == 0)
                            send_byte(CH_NEWLINE, 1'b0);
                    end
                    send_byte(CH_NEWLINE, 1'b0);
                    for (int i = 0; i < nest; i++)
                    begin
                        send_byte(CH_RBRACE, 1'b0);
                        if ($urandom_range(0, 5) == 0)
                            send_byte(CH_NEWLINE, 1'b0);
                    end
                end
                default:
                begin
                    doc = ($urandom_range(0, 7) == 0);
                    len = $urandom_range(10, 40);
                    for (int i = 0; i < len; i++)
                        send_byte(text_byte(), doc && i == 0);
                end
            endcase
            first_seg = 1'b0;
        end

        // Last part without idling: back-to-back folds and an escaped string
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
        send_byte(CH_LBRACE, 1'b1);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_LOWER_A, 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
        repeat (10)
        begin
            send_byte(CH_LBRACE, 1'b0);
            send_byte(CH_NEWLINE, 1'b0);
            send_byte(CH_RBRACE, 1'b0);
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then keep watching for any stray beat
        waited = 0;
        while (regions_waiting != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        $display("Covered %0d source bytes: %0d fold regions, %0d stack overflows seen.",
                 bytes_seen, folds_seen, overflows_seen);
        $display("Included a long sink stall, string and comment modes, stack overflow.");
        if (fail_count == 0 && regions_waiting == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            if (regions_waiting != 0)
                $error("%0d predicted results never arrived", regions_waiting);
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/bfrt_pkg.sv
hdl/bfrt_scanner.sv
hdl/bfrt_stack_mem.sv
hdl/bfrt_result.sv
hdl/brace_fold_region_tracker_top.sv
test/bfrt_checker.sv
test/brace_fold_region_tracker_top_tb.sv
